[hw/rtl/umst_pkg.sv]
// Shared constants, codes and control structs of the unique member set table.
`default_nettype none

package umst_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths on the stream ports
    localparam int FUNC_W     = 3;
    localparam int KEY_PORT_W = 32;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 3;
    localparam int CNT_OUT_W  = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    // Width at which a position is compared with the entry count
    localparam int POS_CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Significant key bits
    localparam logic [KEY_PORT_W-1:0] KEY_MASK = (KEY_WIDTH >= KEY_PORT_W) ? '1 :
        KEY_PORT_W'((64'd1 << KEY_WIDTH) - 64'd1);

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD      = 3'd0,
        FN_REMOVE   = 3'd1,
        FN_CONTAINS = 3'd2,
        FN_READ     = 3'd3,
        FN_REM_POS  = 3'd4,
        FN_CLEAR    = 3'd5,
        FN_FIND     = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 3'd0,
        STS_ZERO   = 3'd1,
        STS_DUP    = 3'd2,
        STS_ABSENT = 3'd3,
        STS_RANGE  = 3'd4,
        STS_FULL   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_POS_KEY,
        S_REMOVE,
        S_MOVE,
        S_MOVE_END,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    op_load;
        logic    srch_run;
        logic    hit_capture;
        logic    pos_read;
        logic    kout_capture;
        logic    add_write;
        logic    move_start;
        logic    move_run;
        logic    cnt_dec;
        logic    cnt_clear;
        logic    set_status;
        status_t status;
        logic    res_push;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              key_zero;
        logic              srch_hit;
        logic              srch_miss;
        logic              table_full;
        logic              pos_valid;
        logic              slot_is_last;
        logic              move_last;
        logic              out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/umst_ctrl.sv]
// Controller state machine that sequences search, read, move and result steps.
`default_nettype none

module umst_ctrl
    import umst_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (sts.func)
                    FN_ADD, FN_REMOVE, FN_CONTAINS, FN_FIND: begin
                        state_next = sts.key_zero ? S_FINISH : S_SEARCH;
                    end
                    FN_READ, FN_REM_POS: begin
                        state_next = sts.pos_valid ? S_POS_KEY : S_FINISH;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_SEARCH: begin
                if (sts.srch_hit) begin
                    state_next = (sts.func == FN_REMOVE) ? S_REMOVE : S_FINISH;
                end else if (sts.srch_miss) begin
                    state_next = S_FINISH;
                end
            end
            S_POS_KEY: begin
                state_next = (sts.func == FN_REM_POS) ? S_REMOVE : S_FINISH;
            end
            S_REMOVE: begin
                state_next = sts.slot_is_last ? S_FINISH : S_MOVE;
            end
            S_MOVE: begin
                if (sts.move_last) state_next = S_MOVE_END;
            end
            S_MOVE_END: state_next = S_FINISH;
            S_FINISH: begin
                if (!sts.out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready    = 1'b1;
                cmd.op_load = in_valid;
            end
            S_DECODE: begin
                unique case (sts.func)
                    FN_ADD, FN_REMOVE, FN_CONTAINS, FN_FIND: begin
                        if (sts.key_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_ZERO;
                        end
                    end
                    FN_READ, FN_REM_POS: begin
                        if (sts.pos_valid) begin
                            cmd.pos_read = 1'b1;
                        end else begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_RANGE;
                        end
                    end
                    FN_CLEAR: cmd.cnt_clear = 1'b1;
                    default: ;
                endcase
            end
            S_SEARCH: begin
                cmd.srch_run = 1'b1;
                if (sts.srch_hit) begin
                    cmd.hit_capture = 1'b1;
                    if (sts.func == FN_ADD) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = STS_DUP;
                    end
                end else if (sts.srch_miss) begin
                    if (sts.func == FN_ADD) begin
                        if (sts.table_full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STS_FULL;
                        end else begin
                            cmd.add_write = 1'b1;
                        end
                    end else begin
                        cmd.set_status = 1'b1;
                        cmd.status     = STS_ABSENT;
                    end
                end
            end
            S_POS_KEY: cmd.kout_capture = 1'b1;
            S_REMOVE: begin
                if (sts.slot_is_last) begin
                    cmd.cnt_dec = 1'b1;
                end else begin
                    cmd.move_start = 1'b1;
                end
            end
            S_MOVE:     cmd.move_run = 1'b1;
            S_MOVE_END: cmd.cnt_dec  = 1'b1;
            S_FINISH:   cmd.res_push = !sts.out_busy;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/umst_datapath.sv]
// Datapath: key memory, entry count, search and move pipelines, result register.
`default_nettype none

module umst_datapath
    import umst_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  swap_mode,
    input  wire logic [FUNC_W-1:0]     in_func,
    input  wire logic [KEY_PORT_W-1:0] in_key,
    input  wire logic [POS_W-1:0]      in_position,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 sts,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [STATUS_W-1:0]        out_status,
    output logic                       out_found,
    output logic [POS_W-1:0]           out_found_position,
    output logic [KEY_PORT_W-1:0]      out_key,
    output logic [CNT_OUT_W-1:0]       out_entry_count
);

    // Key store
    logic [KEY_PORT_W-1:0] key_mem [TABLE_DEPTH];
    logic [KEY_PORT_W-1:0] rdata_reg;
    logic [IDX_W-1:0]      rd_addr;

    // Request registers
    logic [FUNC_W-1:0]     func_reg;
    logic [KEY_PORT_W-1:0] key_reg;
    logic [POS_W-1:0]      pos_reg;

    // Table count and working indexes
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] src_reg;
    logic [IDX_W-1:0] dst_reg;
    logic [IDX_W-1:0] wr_dst_reg;
    logic             wr_pend_reg;

    // Result being built, and the output register
    status_t          res_status_reg;
    logic             res_found_reg;
    logic [IDX_W-1:0] res_fpos_reg;
    logic [KEY_PORT_W-1:0] res_kout_reg;

    logic                  out_vld_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic                  out_found_reg;
    logic [POS_W-1:0]      out_fpos_reg;
    logic [KEY_PORT_W-1:0] out_key_reg;
    logic [CNT_OUT_W-1:0]  out_cnt_reg;

    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     count_idx;
    logic [IDX_W-1:0]     pos_idx;
    logic                 match;
    logic [CNT_W-1:0]     cmp_cnt;

    assign last_idx  = IDX_W'(count_reg - CNT_W'(1));
    assign count_idx = IDX_W'(count_reg);
    assign pos_idx   = IDX_W'(pos_reg);
    assign cmp_cnt   = CNT_W'(cmp_idx_reg);

    // Compare the entry read in the previous cycle with the request key
    assign match = cmp_vld_reg && (rdata_reg == key_reg) && (cmp_cnt < count_reg);

    // Select the read address
    always_comb begin
        priority if (cmd.pos_read) begin
            rd_addr = pos_idx;
        end else if (cmd.move_run) begin
            rd_addr = src_reg;
        end else begin
            rd_addr = scan_idx_reg;
        end
    end

    // Read and write the key store
    always_ff @(posedge aclk) begin
        rdata_reg <= key_mem[rd_addr];
        if (cmd.add_write) begin
            key_mem[count_idx] <= key_reg;
        end else if (wr_pend_reg) begin
            key_mem[wr_dst_reg] <= rdata_reg;
        end
    end

    // Control registers: count and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.cnt_clear) begin
                count_reg <= '0;
            end else if (cmd.add_write) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            cmp_vld_reg <= cmd.srch_run;
            wr_pend_reg <= cmd.move_run;
            if (cmd.res_push) begin
                out_vld_reg <= 1'b1;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Latch the request, advance the scan and move indexes, build the result
    always_ff @(posedge aclk) begin
        if (cmd.op_load) begin
            func_reg       <= in_func;
            key_reg        <= in_key & KEY_MASK;
            pos_reg        <= in_position;
            scan_idx_reg   <= '0;
            res_status_reg <= STS_OK;
            res_found_reg  <= 1'b0;
            res_fpos_reg   <= '0;
            res_kout_reg   <= '0;
        end
        if (cmd.srch_run) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            cmp_idx_reg  <= scan_idx_reg;
        end
        if (cmd.hit_capture) begin
            res_found_reg <= 1'b1;
            res_fpos_reg  <= cmp_idx_reg;
            slot_reg      <= cmp_idx_reg;
        end
        if (cmd.pos_read) begin
            res_found_reg <= 1'b1;
            res_fpos_reg  <= pos_idx;
            slot_reg      <= pos_idx;
        end
        if (cmd.kout_capture) begin
            res_kout_reg <= rdata_reg;
        end
        if (cmd.add_write) begin
            res_fpos_reg <= count_idx;
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status;
        end
        if (cmd.move_start) begin
            dst_reg <= slot_reg;
            src_reg <= swap_mode ? last_idx : slot_reg + IDX_W'(1);
        end
        if (cmd.move_run) begin
            src_reg    <= src_reg + IDX_W'(1);
            dst_reg    <= dst_reg + IDX_W'(1);
            wr_dst_reg <= dst_reg;
        end
        if (cmd.res_push) begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_fpos_reg   <= POS_W'(res_fpos_reg);
            out_key_reg    <= res_kout_reg;
            out_cnt_reg    <= CNT_OUT_W'(count_reg);
        end
    end

    // Report status to the controller
    always_comb begin
        sts.func         = func_reg;
        sts.key_zero     = (key_reg == '0);
        sts.srch_hit     = match;
        sts.srch_miss    = (count_reg == '0) ||
                           (cmp_vld_reg && !match && (cmp_cnt + CNT_W'(1) >= count_reg));
        sts.table_full   = (count_reg == CNT_W'(TABLE_DEPTH));
        sts.pos_valid    = (POS_CMP_W'(pos_reg) < POS_CMP_W'(count_reg));
        sts.slot_is_last = (slot_reg == last_idx);
        sts.move_last    = (src_reg == last_idx);
        sts.out_busy     = out_vld_reg && !out_ready;
    end

    assign out_valid          = out_vld_reg;
    assign out_status         = out_status_reg;
    assign out_found          = out_found_reg;
    assign out_found_position = out_fpos_reg;
    assign out_key            = out_key_reg;
    assign out_entry_count    = out_cnt_reg;

endmodule

`default_nettype wire

[hw/rtl/unique_member_set_table_unit.sv]
// Top level of the unique member set table: stream ports, register port, wiring.
`default_nettype none

// Unique member set table. Holds up to TABLE_DEPTH distinct nonzero keys,
// in insertion order unless a swap removal moves the last entry into the freed
// slot, and performs one request at a time: add, remove by key, contains, read
// by position, remove by position, clear or find. Every request yields one
// result with status, found flag, position, key and entry count. A key lookup
// scans the stored entries in order; a removal then moves entries: the last
// one into the freed slot in swap mode, or each later one down a slot in
// ordered mode, with no move when the slot is the last one. The key memory
// serves one search compare or one entry move per cycle.
// A new request is taken once the previous one is finished, while its result
// may still wait in the output register; a stalled result holds the next one
// in its final cycle. swap_remove_mode reads back at address 0; a write to
// any address sets it.

module unique_member_set_table_unit
    import umst_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // tdata: func[2:0], key[34:3], position[38:35], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: status[2:0], found[3], found_position[7:4], key_out[39:8],
    //        entry_count[44:40], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [1:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    logic       swap_mode_reg;

    logic [STATUS_W-1:0]   out_status;
    logic                  out_found;
    logic [POS_W-1:0]      out_fpos;
    logic [KEY_PORT_W-1:0] out_key;
    logic [CNT_OUT_W-1:0]  out_cnt;

    // Write the mode register on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            swap_mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0) ? {31'd0, swap_mode_reg} : 32'd0;

    umst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    umst_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .swap_mode          (swap_mode_reg),
        .in_func            (s_tdata[2:0]),
        .in_key             (s_tdata[34:3]),
        .in_position        (s_tdata[38:35]),
        .cmd                (cmd),
        .sts                (sts),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .out_status         (out_status),
        .out_found          (out_found),
        .out_found_position (out_fpos),
        .out_key            (out_key),
        .out_entry_count    (out_cnt)
    );

    // Pack the result
    assign m_tdata = {3'd0, out_cnt, out_key, out_fpos, out_found, out_status};

endmodule

`default_nettype wire

[hw/rtl/umst_checker.sv]
// Port-level checker for the unique member set table, bound to the top level.
`default_nettype none

module umst_checker
    import umst_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // The count never exceeds the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[44:40] <= CNT_OUT_W'(TABLE_DEPTH)))
        else $error("entry count beyond table depth");

    // A bad position reports nothing found and no key
    a_range_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == STS_RANGE) |->
            !m_tdata[3] && (m_tdata[39:8] == '0) && (m_tdata[7:4] == '0))
        else $error("out of range result carries data");

    // A zero key or absent key is never reported as found
    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[2:0] == STS_ZERO) || (m_tdata[2:0] == STS_ABSENT)) |->
            !m_tdata[3] && (m_tdata[7:4] == '0))
        else $error("missed key reported as found");

endmodule

bind unique_member_set_table_unit umst_checker u_umst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
